@@ sv/tahs_pkg.sv @@
// Package for the two-axis homing sequencer: phase and direction codes,
// register indexes, reset values and the structs passed between modules.
// No dependencies; every other file of the block imports it.
package tahs_pkg;

    // Widths fixed by the register map and the item fields
    localparam int unsigned LimitW    = 16;
    localparam int unsigned StepsW    = 17;
    localparam int unsigned TimeW     = 32;
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned InDataW   = 40;
    localparam int unsigned OutDataW  = 8;

    // Register reset values
    localparam logic [LimitW-1:0] YSearchLimitRst  = 16'd16000;
    localparam logic [LimitW-1:0] YBackoffLimitRst = 16'd4000;
    localparam logic [LimitW-1:0] XSearchLimitRst  = 16'd16000;
    localparam logic [LimitW-1:0] XBackoffLimitRst = 16'd4000;
    localparam logic [LimitW-1:0] DebounceMsRst    = 16'd500;

    // Configuration register indexes
    typedef enum logic [CfgIndexW-1:0] {
        REG_Y_SEARCH_LIMIT  = 3'd0,
        REG_Y_BACKOFF_LIMIT = 3'd1,
        REG_X_SEARCH_LIMIT  = 3'd2,
        REG_X_BACKOFF_LIMIT = 3'd3,
        REG_DEBOUNCE_MS     = 3'd4
    } cfg_reg_t;

    // Sequencer phases
    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START    = 4'd1,
        PH_Y_DOWN   = 4'd2,
        PH_Y_WAIT   = 4'd3,
        PH_Y_UP     = 4'd4,
        PH_X_LEFT   = 4'd5,
        PH_X_WAIT   = 4'd6,
        PH_X_RIGHT  = 4'd7,
        PH_COMPLETE = 4'd8,
        PH_HALT     = 4'd9
    } phase_t;

    // Step directions
    typedef enum logic [2:0] {
        DIR_NONE  = 3'd0,
        DIR_DOWN  = 3'd1,
        DIR_UP    = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } dir_t;

    // Item opcodes
    typedef enum logic {
        OP_SERVICE = 1'b0,
        OP_BEGIN   = 1'b1
    } op_t;

    typedef struct packed {
        logic [LimitW-1:0] y_search_limit;
        logic [LimitW-1:0] y_backoff_limit;
        logic [LimitW-1:0] x_search_limit;
        logic [LimitW-1:0] x_backoff_limit;
        logic [LimitW-1:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        op_t              op;
        logic             limit_x_pressed;
        logic             limit_y_pressed;
        logic [TimeW-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic step_limit_error;
        logic homing_idle;
        logic keep_going;
        dir_t move_dir;
    } result_t;

endpackage

@@ sv/tahs_cfg.sv @@
// Configuration register bank of the homing sequencer.
// Depends on tahs_pkg for register indexes and reset values.
module tahs_cfg
    import tahs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [LimitW-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    // Write the addressed register; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.y_search_limit  <= YSearchLimitRst;
            cfg_reg.y_backoff_limit <= YBackoffLimitRst;
            cfg_reg.x_search_limit  <= XSearchLimitRst;
            cfg_reg.x_backoff_limit <= XBackoffLimitRst;
            cfg_reg.debounce_ms     <= DebounceMsRst;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_Y_SEARCH_LIMIT:  cfg_reg.y_search_limit  <= cfg_data;
                REG_Y_BACKOFF_LIMIT: cfg_reg.y_backoff_limit <= cfg_data;
                REG_X_SEARCH_LIMIT:  cfg_reg.x_search_limit  <= cfg_data;
                REG_X_BACKOFF_LIMIT: cfg_reg.x_backoff_limit <= cfg_data;
                REG_DEBOUNCE_MS:     cfg_reg.debounce_ms     <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/tahs_in_stage.sv @@
// Input register of the homing sequencer: holds one accepted item.
// Depends on tahs_pkg for the item struct.
module tahs_in_stage
    import tahs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    input  logic  take,
    output logic  item_valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Free when empty or when the held item moves on this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/tahs_core.sv @@
// Sequencer core: phase, step count and debounce deadline, and the
// combinational step that maps one item to one result. Depends on tahs_pkg.
module tahs_core
    import tahs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    advance,
    input  item_t   item,
    output result_t result
);

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [StepsW-1:0]  steps_reg;
    logic [StepsW-1:0]  steps_next;
    logic [TimeW-1:0]   deadline_reg;
    logic [TimeW-1:0]   deadline_next;

    phase_t             cur_phase;
    logic               seek_active;
    logic               seek_level;
    logic               seek_target;
    dir_t               seek_dir;
    phase_t             seek_done_phase;
    logic [LimitW-1:0]  seek_limit;
    logic               over_limit;
    logic               deadline_met;

    // A start phase is serviced as the first Y search step
    assign cur_phase = (phase_reg == PH_START) ? PH_Y_DOWN : phase_reg;

    // Select the switch, direction and limit of the current seek phase
    always_comb
    begin
        seek_active     = 1'b1;
        seek_level      = item.limit_y_pressed;
        seek_target     = 1'b1;
        seek_dir        = DIR_DOWN;
        seek_done_phase = PH_Y_WAIT;
        seek_limit      = cfg.y_search_limit;
        unique case (cur_phase)
            PH_Y_DOWN:
            begin
                seek_active = 1'b1;
            end
            PH_Y_UP:
            begin
                seek_target     = 1'b0;
                seek_dir        = DIR_UP;
                seek_done_phase = PH_X_LEFT;
                seek_limit      = cfg.y_backoff_limit;
            end
            PH_X_LEFT:
            begin
                seek_level      = item.limit_x_pressed;
                seek_dir        = DIR_LEFT;
                seek_done_phase = PH_X_WAIT;
                seek_limit      = cfg.x_search_limit;
            end
            PH_X_RIGHT:
            begin
                seek_level      = item.limit_x_pressed;
                seek_target     = 1'b0;
                seek_dir        = DIR_RIGHT;
                seek_done_phase = PH_COMPLETE;
                seek_limit      = cfg.x_backoff_limit;
            end
            default:
            begin
                seek_active = 1'b0;
            end
        endcase
    end

    assign over_limit   = steps_reg > {1'b0, seek_limit};
    assign deadline_met = item.now_ms >= deadline_reg;

    // Step the sequencer for one item
    always_comb
    begin
        phase_next              = phase_reg;
        steps_next              = steps_reg;
        deadline_next           = deadline_reg;
        result.move_dir         = DIR_NONE;
        result.keep_going       = 1'b1;
        result.step_limit_error = 1'b0;
        if (item.op == OP_BEGIN)
        begin
            phase_next = PH_START;
        end
        else if (seek_active)
        begin
            if (seek_level == seek_target)
            begin
                // Switch reached its target level: arm the debounce wait
                deadline_next = item.now_ms + {{(TimeW-LimitW){1'b0}}, cfg.debounce_ms};
                steps_next    = '0;
                phase_next    = seek_done_phase;
            end
            else if (over_limit)
            begin
                phase_next              = PH_HALT;
                result.keep_going       = 1'b0;
                result.step_limit_error = 1'b1;
            end
            else
            begin
                phase_next      = cur_phase;
                steps_next      = steps_reg + 1'b1;
                result.move_dir = seek_dir;
            end
        end
        else
        begin
            unique case (cur_phase)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_Y_WAIT:
                begin
                    phase_next = deadline_met ? PH_Y_UP : PH_Y_WAIT;
                end
                PH_X_WAIT:
                begin
                    phase_next = deadline_met ? PH_X_RIGHT : PH_X_WAIT;
                end
                PH_COMPLETE:
                begin
                    phase_next        = PH_IDLE;
                    result.keep_going = 1'b0;
                end
                default:
                begin
                    phase_next        = PH_HALT;
                    result.keep_going = 1'b0;
                end
            endcase
        end
        result.homing_idle = (phase_next == PH_IDLE);
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            steps_reg    <= '0;
            deadline_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            steps_reg    <= steps_next;
            deadline_reg <= deadline_next;
        end
    end

endmodule

@@ sv/tahs_out_stage.sv @@
// Result register of the homing sequencer, drained by the output channel.
// Depends on tahs_pkg for the result struct.
module tahs_out_stage
    import tahs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_result,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // Room for a new result when empty or when the held one transfers now
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (free)
        begin
            valid_next = load;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until it transfers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= load_result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

@@ sv/two_axis_homing_sequencer.sv @@
// Top level of the two-axis homing sequencer: stream ports, register bank,
// input register, sequencer core and result register. Depends on tahs_pkg.
//
// Usage:
//   Each item on the s_ channel is either a begin request (s_tuser = 1) or a
//   service request (s_tuser = 0) with both switch levels and the current
//   millisecond time. Every item yields exactly one result on the m_ channel:
//   the step to take, a keep-going flag, an idle flag and a step-limit flag.
//   Limits and the debounce time are written through cfg_we / cfg_index /
//   cfg_data while no item is in flight.
//   Path: m_tvalid rises once the item has passed the input register and then
//   the result register; a low m_tready can hold it in the input register.
//   Throughput: one item per cycle while m_tready is high; the core updates its
//   state as each item moves to the result register.
//   Reset: both pipeline registers empty, phase idle, step count and deadline
//   zero, registers at their reset values.
//   Stall: while m_tready is low the result holds; one more item may enter and
//   wait in the input register, after which s_tready drops.
module two_axis_homing_sequencer
    import tahs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [LimitW-1:0]    cfg_data,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [InDataW-1:0]   s_tdata,   // [0] limit_x_pressed, [1] limit_y_pressed,
                                            // [33:2] now_ms, [39:34] zero
    input  logic                 s_tuser,   // [0] op
    // Output stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OutDataW-1:0]  m_tdata    // [2:0] move_dir, [3] keep_going,
                                            // [4] homing_idle, [5] step_limit_error,
                                            // [7:6] zero
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    advance;
    result_t step_result;
    result_t out_result;

    // Unpack the input transfer
    assign in_item.op              = op_t'(s_tuser);
    assign in_item.limit_x_pressed = s_tdata[0];
    assign in_item.limit_y_pressed = s_tdata[1];
    assign in_item.now_ms          = s_tdata[TimeW+1:2];

    // Move an item to the result register when both sides allow
    assign advance = item_valid && out_free;

    tahs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tahs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tahs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .item    (item),
        .result  (step_result)
    );

    tahs_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .load_result (step_result),
        .free        (out_free),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_result  (out_result)
    );

    // Pack the result transfer
    assign m_tdata = {{(OutDataW-$bits(result_t)){1'b0}}, out_result};

endmodule

@@ sv/tahs_checker.sv @@
// Port-level checks of the homing sequencer's result stream, bound to the
// top level. Depends on tahs_pkg for direction codes.
module tahs_checker
    import tahs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A step-limit halt moves nothing and stops the motors
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[5] |-> !m_tdata[3] && (m_tdata[2:0] == DIR_NONE))
        else $error("step-limit result with motion or keep_going");

    // A step is only issued mid-sequence with keep_going set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != DIR_NONE) |-> m_tdata[3] && !m_tdata[4])
        else $error("step issued while idle or halting");

    // Direction codes stay in range and pad bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == DIR_NONE || m_tdata[2:0] == DIR_DOWN
                   || m_tdata[2:0] == DIR_UP || m_tdata[2:0] == DIR_LEFT
                   || m_tdata[2:0] == DIR_RIGHT) && (m_tdata[7:6] == 2'b00))
        else $error("bad direction code or pad bits");

endmodule

bind two_axis_homing_sequencer tahs_checker u_tahs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
